/* hw/rtl/shuffled_lehmer_random_generator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled Lehmer generator
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_MACROS_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SLRG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slrg assertion failed");
// Next-cycle implication.
`define SLRG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slrg assertion failed");
`else
`define SLRG_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SLRG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/slrg_pkg.sv */
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and types of the shuffled Lehmer generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

   localparam int SEED_WIDTH  = 32;
   localparam int VALUE_WIDTH = 31;

   localparam int TABLE_DEPTH_DEFAULT = 32;

   // Request action codes
   localparam logic ACT_DRAW = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   // Minimal-standard multiplier and Mersenne modulus 2^31 - 1
   localparam logic [14:0] LEH_MULT = 15'd16807;
   localparam logic [30:0] LEH_MOD  = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_DIV,
      ST_SWAP,
      ST_DONE
   } slrg_state_type;

endpackage

/* hw/rtl/slrg_req_if.sv */
// ----------------------------------------------------------------------------
// slrg_req_if
// Request channel: draw or load-seed-and-draw, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slrg_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic signed [slrg_pkg::SEED_WIDTH-1:0] seed_value;

   modport source (output valid, output action, output seed_value, input ready);
   modport sink   (input valid, input action, input seed_value, output ready);
endinterface

/* hw/rtl/slrg_rsp_if.sv */
// ----------------------------------------------------------------------------
// slrg_rsp_if
// Response channel: shuffled deviate and generator state, valid/ready.
// ----------------------------------------------------------------------------
interface slrg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [slrg_pkg::VALUE_WIDTH-1:0] random_value;
   logic [slrg_pkg::VALUE_WIDTH-1:0] new_state;

   modport source (output valid, output random_value, output new_state, input ready);
   modport sink   (input valid, input random_value, input new_state, output ready);
endinterface

/* hw/rtl/shuffled_lehmer_random_generator_top.sv */
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_top
// Park-Miller minimal-standard generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per transfer: action 0 draws with the stored
//   state, action 1 loads seed_value first. rsp_chan returns one transfer per
//   request with the shuffled deviate and the generator state after the draw.
//   Sequence: a plain draw steps through MUL, FOLD, DIV, SWAP and DONE before
//   its response is registered. A draw that re-seeds the table (nonpositive
//   working state, or first draw after reset) first runs the warm-up steps
//   that refill it. Requests: one at a time; req_chan.ready is high only while
//   the sequencer is idle, so a new request waits until the last draw leaves
//   DONE. The steps are set by the single shared multiply/fold unit (MUL then
//   FOLD per recurrence step), DIV to turn the index product into a table
//   address and SWAP for the table swap.
//   Reset: state returns to 1 and the shuffle register to 0, so the first draw
//   always fills the table. The table itself is not cleared.
//   Stall: the response sits in an output register; a new request is taken
//   while it waits. If a second response is ready before the first is taken,
//   the sequencer holds in its last state until the output register frees.
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_top_macros.svh"

module shuffled_lehmer_random_generator_top #(
   parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   slrg_req_if.sink          req_chan,
   slrg_rsp_if.source        rsp_chan
);

   localparam int VW = slrg_pkg::VALUE_WIDTH;
   localparam int SW = slrg_pkg::SEED_WIDTH;
   localparam int PW = VW + 16;                         // product width
   localparam int AW = $clog2(TABLE_DEPTH);             // table address
   localparam int QW = $clog2(TABLE_DEPTH + 1);         // index quotient
   localparam int CW = $clog2(TABLE_DEPTH + 8);         // warm-up counter
   localparam longint unsigned SHUF_DIV =
      64'd1 + 64'd2147483646 / 64'(TABLE_DEPTH);
   localparam int DL = $clog2(SHUF_DIV);                // divisor exponent
   localparam int RW = VW + 1;                          // reciprocal width
   localparam int SH = VW + DL;                         // quotient shift
   localparam int MW = VW + RW;                         // index product width
   // Rounded-up reciprocal: exact floor division for every 31-bit dividend
   localparam logic [RW-1:0] SHUF_RECIP =
      RW'(((64'd1 << SH) + SHUF_DIV - 64'd1) / SHUF_DIV);

   // Sequencer and control
   slrg_pkg::slrg_state_type state_ff, state_in;
   logic          init_ff, init_in;
   logic [CW-1:0] step_cnt_ff, step_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Architectural state
   logic [VW-1:0] gen_state_ff, gen_state_in;
   logic [VW-1:0] shuf_out_ff, shuf_out_in;

   // Shared arithmetic unit
   logic [SW-1:0] x_ff, x_in;
   logic [PW-1:0] prod_ff;
   logic [SW-1:0] fold_sum;
   logic [VW-1:0] fold_value;

   // Table index
   logic [MW-1:0] pick_prod_ff;
   logic [QW-1:0] pick_quo;
   logic [AW-1:0] idx_ff, idx_in;

   // Output payload
   logic [VW-1:0] rsp_rand_ff, rsp_rand_in;
   logic [VW-1:0] rsp_state_ff, rsp_state_in;

   // Shuffle table
   logic [VW-1:0] shuffle_mem [TABLE_DEPTH];
   logic [VW-1:0] rd_ff;
   logic [AW-1:0] table_idx;
   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   logic [VW-1:0] tbl_wdata;
   logic          tbl_re;

   // Request decode
   logic signed [SW-1:0] work;
   logic                 need_init;
   logic                 req_fire;
   logic                 rsp_load;

   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_chan.action == slrg_pkg::ACT_LOAD) begin
         work = req_chan.seed_value;
      end else begin
         work = signed'({1'b0, gen_state_ff});
      end
      need_init = work[SW-1] || (work == '0) || (shuf_out_ff == '0);
   end

   // Mersenne fold: p mod (2^31-1) = (p[30:0] + p[high]) with one subtract
   always_comb begin
      fold_sum = {1'b0, prod_ff[VW-1:0]} + SW'(prod_ff[PW-1:VW]);
      if (fold_sum >= {1'b0, slrg_pkg::LEH_MOD}) begin
         fold_value = VW'(fold_sum - {1'b0, slrg_pkg::LEH_MOD});
      end else begin
         fold_value = fold_sum[VW-1:0];
      end
   end

   // Pick index: upper bits of shuffle register times reciprocal
   assign pick_quo = QW'(pick_prod_ff >> SH);

   // Cap the index; unreachable for in-range table entries but kept safe
   assign table_idx = (pick_quo >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                     : pick_quo[AW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slrg_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = slrg_pkg::ST_MUL;
            end
         end
         slrg_pkg::ST_MUL: begin
            state_in = slrg_pkg::ST_FOLD;
         end
         slrg_pkg::ST_FOLD: begin
            if (init_ff) begin
               state_in = slrg_pkg::ST_MUL;
            end else begin
               state_in = slrg_pkg::ST_DIV;
            end
         end
         slrg_pkg::ST_DIV: begin
            state_in = slrg_pkg::ST_SWAP;
         end
         slrg_pkg::ST_SWAP: begin
            state_in = slrg_pkg::ST_DONE;
         end
         slrg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = slrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slrg_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_chan.ready = (state_ff == slrg_pkg::ST_IDLE);
      rsp_load       = (state_ff == slrg_pkg::ST_DONE) &&
                       (!rsp_valid_ff || rsp_chan.ready);
      tbl_re         = (state_ff == slrg_pkg::ST_SWAP);
      tbl_we         = 1'b0;
      tbl_waddr      = idx_ff;
      tbl_wdata      = gen_state_ff;
      case (state_ff)
         slrg_pkg::ST_FOLD: begin
            // Warm-up: keep only the last TABLE_DEPTH steps, highest index first
            tbl_we    = init_ff && (step_cnt_ff < CW'(TABLE_DEPTH));
            tbl_waddr = step_cnt_ff[AW-1:0];
            tbl_wdata = fold_value;
         end
         slrg_pkg::ST_SWAP: begin
            tbl_we = 1'b1;
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      init_in      = init_ff;
      step_cnt_in  = step_cnt_ff;
      gen_state_in = gen_state_ff;
      shuf_out_in  = shuf_out_ff;
      x_in         = x_ff;
      idx_in       = idx_ff;
      rsp_rand_in  = rsp_rand_ff;
      rsp_state_in = rsp_state_ff;
      case (state_ff)
         slrg_pkg::ST_IDLE: begin
            if (req_fire) begin
               init_in     = need_init;
               step_cnt_in = CW'(TABLE_DEPTH + 7);
               if (!need_init) begin
                  x_in = unsigned'(work);
               end else if (work[SW-1]) begin
                  x_in = unsigned'(-work);
               end else begin
                  x_in = SW'(1);
               end
            end
         end
         slrg_pkg::ST_FOLD: begin
            if (init_ff) begin
               x_in = SW'(fold_value);
               if (step_cnt_ff == '0) begin
                  // Entry 0 seeds the shuffle register; the draw step follows
                  shuf_out_in = fold_value;
                  init_in     = 1'b0;
               end else begin
                  step_cnt_in = step_cnt_ff - 1'b1;
               end
            end else begin
               gen_state_in = fold_value;
            end
         end
         slrg_pkg::ST_DIV: begin
            // Hold the capped pick address for the swap
            idx_in = table_idx;
         end
         slrg_pkg::ST_DONE: begin
            if (rsp_load) begin
               shuf_out_in  = rd_ff;
               rsp_rand_in  = rd_ff;
               rsp_state_in = gen_state_ff;
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slrg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
         gen_state_ff <= VW'(1);
         shuf_out_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         gen_state_ff <= gen_state_in;
         shuf_out_ff  <= shuf_out_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_cnt_ff  <= step_cnt_in;
      x_ff         <= x_in;
      prod_ff      <= PW'(x_ff) * PW'(slrg_pkg::LEH_MULT);
      pick_prod_ff <= MW'(shuf_out_ff) * MW'(SHUF_RECIP);
      idx_ff       <= idx_in;
      rsp_rand_ff  <= rsp_rand_in;
      rsp_state_ff <= rsp_state_in;
   end

   // Shuffle table: one write port, one registered read port (read-before-write)
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         shuffle_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         rd_ff <= shuffle_mem[idx_ff];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_rand_ff;
   assign rsp_chan.new_state    = rsp_state_ff;

   // Assertions
   `SLRG_ASSERT_NEXT(a_accept_starts_step, clock, reset, req_fire, state_ff == slrg_pkg::ST_MUL)
   `SLRG_ASSERT_IMPL(a_fold_reduced, clock, reset, state_ff == slrg_pkg::ST_FOLD, fold_value < slrg_pkg::LEH_MOD)
   `SLRG_ASSERT_NEXT(a_done_holds_on_stall, clock, reset, (state_ff == slrg_pkg::ST_DONE) && rsp_valid_ff && !rsp_chan.ready, state_ff == slrg_pkg::ST_DONE)
   `SLRG_ASSERT_IMPL(a_index_in_table, clock, reset, state_ff == slrg_pkg::ST_DIV, pick_quo < QW'(TABLE_DEPTH))
   `SLRG_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == slrg_pkg::ST_DONE)

endmodule
